@@ rtl/core/hybrid_logical_clock_core_defines.svh @@
// ----------------------------------------------------------------------------
// Hybrid logical clock core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HYBRID_LOGICAL_CLOCK_CORE_DEFINES_SVH
`define HYBRID_LOGICAL_CLOCK_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hlc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hlc assertion failed");

`endif

@@ rtl/core/hlc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hybrid logical clock package
// Field widths, operation codes and the structs shared by the core modules.
// ----------------------------------------------------------------------------
package hlc_pkg;

	localparam int unsigned TimeW  = 64;
	localparam int unsigned StampW = 63;
	localparam int unsigned CountW = 32;
	localparam int unsigned NodeW  = 32;
	localparam int unsigned DriftW = 32;

	localparam int unsigned InDataW  = 192;
	localparam int unsigned OutDataW = 128;

	localparam logic [DriftW-1:0] DriftReset = 32'd60000;

	typedef enum logic {
		FUNC_LOCAL   = 1'b0,
		FUNC_OBSERVE = 1'b1
	} hlc_func_t;

	typedef struct packed {
		hlc_func_t          func;
		logic [TimeW-1:0]   now_ms;
		logic [NodeW-1:0]   node_id;
		logic [TimeW-1:0]   remote_time_ms;
		logic [CountW-1:0]  remote_count;
	} hlc_item_t;

	typedef struct packed {
		logic [TimeW-1:0]  time_ms;
		logic [CountW-1:0] count;
	} hlc_state_t;

	typedef struct packed {
		logic [StampW-1:0] stamp_time_ms;
		logic [CountW-1:0] stamp_count;
		logic [NodeW-1:0]  stamp_node;
		logic              drift_clamped;
	} hlc_result_t;

endpackage

@@ rtl/core/hlc_merge.sv @@
// ----------------------------------------------------------------------------
// Hybrid logical clock merge
// Computes the next clock state and the stamp for one local or observe beat.
// ----------------------------------------------------------------------------
module hlc_merge (
	input  hlc_pkg::hlc_item_t         item,
	input  hlc_pkg::hlc_state_t        cur,
	input  logic [hlc_pkg::DriftW-1:0] max_drift_ms,
	output hlc_pkg::hlc_state_t        nxt,
	output hlc_pkg::hlc_result_t       res
);
	import hlc_pkg::*;

	logic [TimeW-1:0]  now_c;
	logic [TimeW:0]    drift_lim;
	logic              clamp;
	logic [TimeW-1:0]  rem_eff;
	logic [TimeW-1:0]  rem_now_max;
	logic [TimeW-1:0]  cand;
	logic [TimeW-1:0]  l_time;
	logic              is_obs;
	logic              tie_prev;
	logic              tie_rem;
	logic [CountW-1:0] from_cnt;

	assign is_obs = (item.func == FUNC_OBSERVE);

	// A negative current time counts as unseeded zero.
	assign now_c = item.now_ms[TimeW-1] ? '0 : item.now_ms;

	// The drift limit is formed one bit wider so that it never wraps.
	assign drift_lim = {1'b0, now_c} + {{(TimeW-DriftW+1){1'b0}}, max_drift_ms};

	assign clamp = is_obs && (now_c != '0) && !item.remote_time_ms[TimeW-1]
		&& ({1'b0, item.remote_time_ms} > drift_lim);

	assign rem_eff = clamp ? now_c : item.remote_time_ms;

	assign rem_now_max = ($signed(now_c) > $signed(rem_eff)) ? now_c : rem_eff;
	assign cand        = is_obs ? rem_now_max : now_c;
	assign l_time      = ($signed(cand) > $signed(cur.time_ms)) ? cand : cur.time_ms;

	assign tie_prev = (l_time == cur.time_ms);
	assign tie_rem  = is_obs && (l_time == rem_eff);

	always_comb begin
		if (tie_prev && tie_rem) begin
			from_cnt = (cur.count > item.remote_count) ? cur.count : item.remote_count;
		end else if (tie_prev) begin
			from_cnt = cur.count;
		end else begin
			from_cnt = item.remote_count;
		end
	end

	always_comb begin
		nxt.time_ms = l_time;
		nxt.count   = '0;
		if (tie_prev || tie_rem) begin
			// An all-ones counter spends a millisecond instead of wrapping.
			if (&from_cnt) begin
				nxt.time_ms = l_time + {{(TimeW-1){1'b0}}, 1'b1};
			end else begin
				nxt.count = from_cnt + {{(CountW-1){1'b0}}, 1'b1};
			end
		end
	end

	assign res.stamp_time_ms = nxt.time_ms[StampW-1:0];
	assign res.stamp_count   = nxt.count;
	assign res.stamp_node    = is_obs ? '0 : item.node_id;
	assign res.drift_clamped = clamp;

endmodule

@@ rtl/core/hybrid_logical_clock_core.sv @@
// ----------------------------------------------------------------------------
// Hybrid logical clock core
// Keeps a millisecond time and event counter; stamps local events and merges
// remote stamps under a configurable drift limit.
// ----------------------------------------------------------------------------
//
// Channel  Role    Handshake              Payload
// s_*      in      s_tvalid / s_tready    s_tuser func, s_tdata item fields
// m_*      out     m_tvalid / m_tready    m_tuser drift flag, m_tdata stamp
// cfg_*    in      cfg_valid / cfg_ready  cfg_data max_drift_ms
//
// One beat is taken every cycle while s_tready is high. Its stamp is shown on
// m_tvalid once it has passed the input and result registers; a waiting
// result holds the beat behind it. The single clock-state update runs the
// merge logic once per beat between the input and result registers.
// Reset clears the clock to zero time and count and loads a drift limit of
// 60000 ms. While the result waits on m_tready the input register still takes
// one more beat, then s_tready drops until the result is taken.
//
module hybrid_logical_clock_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input beat.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// From bit 0: now_ms[63:0], node_id[31:0], remote_time_ms[63:0],
	// remote_count[31:0].
	input  logic [hlc_pkg::InDataW-1:0]  s_tdata,
	// func: 0 local event, 1 observe remote stamp.
	input  logic                         s_tuser,
	// Result beat.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// From bit 0: stamp_time_ms[62:0], stamp_count[31:0], stamp_node[31:0],
	// one zero pad bit.
	output logic [hlc_pkg::OutDataW-1:0] m_tdata,
	// drift_clamped.
	output logic                         m_tuser,
	// Configuration write of max_drift_ms.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hlc_pkg::DriftW-1:0]   cfg_data
);
	import hlc_pkg::*;

	hlc_item_t          item_s1;
	logic               vld_s1;
	hlc_result_t        res_q;
	logic               out_vld_q;
	hlc_state_t         clk_state_q;
	logic [DriftW-1:0]  max_drift_q;

	hlc_item_t          item_in;
	hlc_state_t         state_nxt;
	hlc_result_t        res_nxt;
	logic               out_free;
	logic               adv;
	logic               take_in;

	// Unpack the input beat.
	assign item_in.func           = hlc_func_t'(s_tuser);
	assign item_in.now_ms         = s_tdata[63:0];
	assign item_in.node_id        = s_tdata[95:64];
	assign item_in.remote_time_ms = s_tdata[159:96];
	assign item_in.remote_count   = s_tdata[191:160];

	// The result register frees up when empty or when its beat is taken.
	assign out_free = !out_vld_q || m_tready;
	assign adv      = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;
	assign take_in  = s_tvalid && s_tready;

	// Configuration always accepted; user keeps block idle if written, unchecked.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_drift_q <= DriftReset;
		end else if (cfg_valid) begin
			max_drift_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_in) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item_in;
		end
	end

	hlc_merge u_merge (
		.item         (item_s1),
		.cur          (clk_state_q),
		.max_drift_ms (max_drift_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// Clock state moves only when a beat leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_state_q <= '0;
		end else if (adv) begin
			clk_state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, res_q.stamp_node, res_q.stamp_count, res_q.stamp_time_ms};
	assign m_tuser  = res_q.drift_clamped;

`include "hybrid_logical_clock_core_defines.svh"

	// The stamp shown always matches the clock state it was taken from.
	`HLC_ASSERT_NEXT(a_stamp_matches_state, adv, (m_tdata[62:0] == clk_state_q.time_ms[62:0]) && (m_tdata[94:63] == clk_state_q.count))

	// Local events never raise the drift flag.
	`HLC_ASSERT_NEXT(a_local_no_clamp, adv && (item_s1.func == FUNC_LOCAL), !m_tuser)

	// Observe stamps carry a zero node id.
	`HLC_ASSERT_NEXT(a_observe_zero_node, adv && (item_s1.func == FUNC_OBSERVE), m_tdata[126:95] == '0)

	// Input backpressure only when both registers are full and stalled.
	`HLC_ASSERT_NOW(a_ready_only_when_full, !s_tready, vld_s1 && out_vld_q && !m_tready)

endmodule
